/* src/pdds_pkg.sv */
// Shared types and character codes for the primer degeneracy and deletion screen.
package pdds_pkg;

    localparam int CODE_W = 8;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = 7;
    localparam int COST_W = 3;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [1:0]        t_score;
    typedef logic [COST_W-1:0] t_cost;

    localparam t_code CH_LOWER_A = 8'h61;
    localparam t_code CH_LOWER_Z = 8'h7A;
    localparam t_code CASE_DIFF  = 8'h20;
    localparam t_code CH_A       = 8'h41;
    localparam t_code CH_B       = 8'h42;
    localparam t_code CH_C       = 8'h43;
    localparam t_code CH_D       = 8'h44;
    localparam t_code CH_G       = 8'h47;
    localparam t_code CH_H       = 8'h48;
    localparam t_code CH_N       = 8'h4E;
    localparam t_code CH_T       = 8'h54;
    localparam t_code CH_V       = 8'h56;
    localparam t_code CH_DASH    = 8'h2D;

    localparam t_score SCORE_MAX  = 2'd3;
    localparam int     END_ZONE   = 3;
    localparam int     MAX_DELS   = 3;
    localparam t_len   MIN_LEN_RST = 7'd18;

    // Degeneracy cost of one code; near selects the end-zone weight of 3 for B, D, H, V and other codes.
    function automatic t_cost code_cost(input t_code c, input logic near);
        t_code u;
        t_cost res;
        u = c;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            u = c - CASE_DIFF;
        end
        unique case (u)
            CH_N:                   res = 3'd3;
            CH_B, CH_D, CH_H, CH_V: res = near ? 3'd6 : 3'd2;
            CH_A, CH_C, CH_G, CH_T, CH_DASH: res = 3'd0;
            default:                res = near ? 3'd3 : 3'd1;
        endcase
        return res;
    endfunction

endpackage

/* src/pdds_in_if.sv */
// Input channel: one primer code character per word.
interface pdds_in_if
    import pdds_pkg::*;
;
    logic  valid;
    logic  ready;
    t_code code;
    t_len  primer_length;

    modport source (output valid, output code, output primer_length, input ready);
    modport sink   (input valid, input code, input primer_length, output ready);
endinterface

/* src/pdds_out_if.sv */
// Output channel: one verdict word per primer.
interface pdds_out_if
    import pdds_pkg::*;
;
    logic valid;
    logic ready;
    logic degeneracy_reject;
    logic deletion_reject;
    t_cnt deletion_total;

    modport source (output valid, output degeneracy_reject, output deletion_reject,
                    output deletion_total, input ready);
    modport sink   (input valid, input degeneracy_reject, input deletion_reject,
                    input deletion_total, output ready);
endinterface

/* src/primer_degeneracy_deletion_screen.sv */
// Top level of the primer degeneracy and deletion screen.
//
// Takes one primer code character per cycle on i_in, every word carrying the
// primer length, and emits one verdict word on o_out at the last position of
// each primer. Throughput is one word per cycle while i_in.ready is high: the
// per-primer accumulators (position, saturating degeneracy score, deletion
// count, flag) update in the cycle a word is accepted; the verdict lands in
// an output register the cycle after the last character. i_in.ready stays
// high while the output register is empty or draining, so a pending verdict
// only stalls the input when o_out.ready is low. Zero length is taken as one,
// lengths above MAX_PRIMER_LENGTH are clipped. The user must write the minimum
// usable length (i_cfg_we/i_cfg_wdata, reset 18) only while idle; unenforced.
module primer_degeneracy_deletion_screen
    import pdds_pkg::*;
#(
    parameter int MAX_PRIMER_LENGTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_len              i_cfg_wdata,
    pdds_in_if.sink           i_in,
    pdds_out_if.source        o_out
);

    localparam int PW  = $clog2(MAX_PRIMER_LENGTH);
    // compare width: holds positions, lengths and count + minimum sums
    localparam int LW  = ((PW + 1 > LEN_W) ? PW + 1 : LEN_W) + 1;

    logic [PW-1:0] r_pos,      n_pos;
    t_score        r_score,    n_score;
    t_cnt          r_del_cnt,  n_del_cnt;
    logic          r_del_flag, n_del_flag;
    t_len          r_min_len;

    logic          r_out_valid;
    logic          r_out_degen;
    logic          r_out_del;
    t_cnt          r_out_total;

    logic          accept;
    logic [LW-1:0] len_ext;
    logic [LW-1:0] pos_ext;
    logic          near_end;
    logic          last_pos;
    logic          is_dash;
    logic [3:0]    score_sum;
    logic          del_rej;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // clip length into 1..MAX_PRIMER_LENGTH
    always_comb begin
        len_ext = LW'(i_in.primer_length);
        if (len_ext == '0) begin
            len_ext = LW'(1);
        end else if (len_ext > LW'(MAX_PRIMER_LENGTH)) begin
            len_ext = LW'(MAX_PRIMER_LENGTH);
        end
    end

    assign pos_ext  = LW'(r_pos);
    assign near_end = (pos_ext < LW'(END_ZONE)) || (pos_ext + LW'(END_ZONE) >= len_ext);
    assign last_pos = (pos_ext + LW'(1) >= len_ext);
    assign is_dash  = (i_in.code == CH_DASH);

    // per-character accumulator update
    always_comb begin
        score_sum  = 4'(r_score) + 4'(code_cost(i_in.code, near_end));
        n_score    = (score_sum >= 4'(SCORE_MAX)) ? SCORE_MAX : score_sum[1:0];
        n_del_cnt  = r_del_cnt;
        n_del_flag = r_del_flag;
        if (is_dash) begin
            if (r_del_cnt != '1) begin
                n_del_cnt = r_del_cnt + CNT_W'(1);
            end
            if (near_end) begin
                n_del_flag = 1'b1;
            end
        end
        if (n_del_cnt > CNT_W'(MAX_DELS)) begin
            n_del_flag = 1'b1;
        end
        del_rej = n_del_flag || (LW'(n_del_cnt) + LW'(r_min_len) > len_ext);
        n_pos   = PW'(pos_ext + LW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_score     <= '0;
            r_del_cnt   <= '0;
            r_del_flag  <= 1'b0;
            r_min_len   <= MIN_LEN_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_len <= i_cfg_wdata;
            end
            // a new verdict wins over draining the old one
            if (accept && last_pos) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                if (last_pos) begin
                    // primer ends here: verdict goes out, clear accumulators
                    r_pos       <= '0;
                    r_score     <= '0;
                    r_del_cnt   <= '0;
                    r_del_flag  <= 1'b0;
                end else begin
                    r_pos      <= n_pos;
                    r_score    <= n_score;
                    r_del_cnt  <= n_del_cnt;
                    r_del_flag <= n_del_flag;
                end
            end
        end
    end

    // verdict payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && last_pos) begin
            r_out_degen <= (n_score >= SCORE_MAX);
            r_out_del   <= del_rej;
            r_out_total <= n_del_cnt;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.degeneracy_reject = r_out_degen;
    assign o_out.deletion_reject   = r_out_del;
    assign o_out.deletion_total    = r_out_total;

endmodule
